>>> src/lel_pkg.sv
// ----------------------------------------------------------------------------
// lel_pkg: shared definitions for the logic expression lexer
// Token codes, character constants, queue entry type and identifier limit.
// ----------------------------------------------------------------------------
package lel_pkg;

  typedef enum logic [3:0] {
    TK_SEMI    = 4'd0,
    TK_NOT     = 4'd1,
    TK_AND     = 4'd2,
    TK_OR      = 4'd3,
    TK_XOR     = 4'd4,
    TK_EQV     = 4'd5,
    TK_EQP     = 4'd6,
    TK_IMP     = 4'd7,
    TK_LPAREN  = 4'd8,
    TK_RPAREN  = 4'd9,
    TK_ID      = 4'd10,
    TK_IDCHAR  = 4'd11
  } token_kind_e;

  localparam logic [7:0] CH_AMP    = 8'h26; // '&'
  localparam logic [7:0] CH_BAR    = 8'h7C; // '|'
  localparam logic [7:0] CH_LT     = 8'h3C; // '<'
  localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
  localparam logic [7:0] CH_GT     = 8'h3E; // '>'
  localparam logic [7:0] CH_EQ     = 8'h3D; // '='
  localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
  localparam logic [7:0] CH_TILDE  = 8'h7E; // '~'
  localparam logic [7:0] CH_CARET  = 8'h5E; // '^'
  localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
  localparam logic [7:0] CH_LPAREN = 8'h28; // '('
  localparam logic [7:0] CH_RPAREN = 8'h29; // ')'

  localparam int MAX_ID_LEN = 32;
  localparam logic [5:0] ID_LIMIT = 6'((MAX_ID_LEN > 63) ? 63 : MAX_ID_LEN);

  localparam int FIFO_DEPTH = 4;

  // One queue entry: one or two tokens caused by a single input byte.
  typedef struct packed {
    logic        two;
    token_kind_e tok0;
    token_kind_e tok1;
  } lel_entry_t;

  typedef struct packed {
    logic       push;
    lel_entry_t entry;
  } lel_push_t;

  typedef struct packed {
    logic       empty;
    lel_entry_t entry;
  } lel_head_t;

endpackage

>>> src/lel_byte_if.sv
// ----------------------------------------------------------------------------
// lel_byte_if: input character channel
// Valid/ready channel carrying one expression character per request.
// ----------------------------------------------------------------------------
interface lel_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> src/lel_token_if.sv
// ----------------------------------------------------------------------------
// lel_token_if: output token channel
// Valid/ready channel carrying one token code per request.
// ----------------------------------------------------------------------------
interface lel_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink (input valid, input token_kind, output ready);
endinterface

>>> src/lel_front.sv
// ----------------------------------------------------------------------------
// lel_front: scanner front end
// Accepts characters, runs the scan state machine, queues the tokens.
// ----------------------------------------------------------------------------
module lel_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  lel_byte_if.sink          in_i,
  input  logic              full_i,
  output lel_pkg::lel_push_t push_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_AMP      = 8'b0000_0010,
    ST_BAR      = 8'b0000_0100,
    ST_LT       = 8'b0000_1000,
    ST_LT_MINUS = 8'b0001_0000,
    ST_LT_EQ    = 8'b0010_0000,
    ST_MINUS    = 8'b0100_0000,
    ST_IDENT    = 8'b1000_0000
  } scan_state_e;

  typedef struct packed {
    logic                 emit;
    lel_pkg::token_kind_e tok;
    scan_state_e          nxt;
  } idle_res_t;

  function automatic idle_res_t scan_idle(input logic [7:0] c);
    idle_res_t r;
    r.emit = 1'b1;
    r.tok  = lel_pkg::TK_SEMI;
    r.nxt  = ST_IDLE;
    case (c)
      lel_pkg::CH_SEMI:   r.tok = lel_pkg::TK_SEMI;
      lel_pkg::CH_TILDE:  r.tok = lel_pkg::TK_NOT;
      lel_pkg::CH_CARET:  r.tok = lel_pkg::TK_XOR;
      lel_pkg::CH_LPAREN: r.tok = lel_pkg::TK_LPAREN;
      lel_pkg::CH_RPAREN: r.tok = lel_pkg::TK_RPAREN;
      lel_pkg::CH_AMP:    begin r.emit = 1'b0; r.nxt = ST_AMP;   end
      lel_pkg::CH_BAR:    begin r.emit = 1'b0; r.nxt = ST_BAR;   end
      lel_pkg::CH_LT:     begin r.emit = 1'b0; r.nxt = ST_LT;    end
      lel_pkg::CH_MINUS:  begin r.emit = 1'b0; r.nxt = ST_MINUS; end
      lel_pkg::CH_DOLLAR: begin r.emit = 1'b0; r.nxt = ST_IDENT; end
      default:            r.tok = lel_pkg::TK_SEMI;
    endcase
    return r;
  endfunction

  scan_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        accept;
  logic        is_id;
  idle_res_t   idle_r;
  logic [7:0]  c;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign c          = in_i.in_byte;

  assign is_id = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                 ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h5F);

  assign idle_r = scan_idle(c);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    push_o.push     = 1'b0;
    push_o.entry.two  = 1'b0;
    push_o.entry.tok0 = lel_pkg::TK_SEMI;
    push_o.entry.tok1 = lel_pkg::TK_SEMI;
    if (accept) begin
      case (state_q)
        ST_AMP, ST_BAR, ST_MINUS, ST_LT_MINUS, ST_LT_EQ: begin
          state_d     = ST_IDLE;
          push_o.push = 1'b1;
          if ((state_q == ST_AMP) && (c == lel_pkg::CH_AMP)) begin
            push_o.entry.tok0 = lel_pkg::TK_AND;
          end else if ((state_q == ST_BAR) && (c == lel_pkg::CH_BAR)) begin
            push_o.entry.tok0 = lel_pkg::TK_OR;
          end else if ((state_q == ST_MINUS) && (c == lel_pkg::CH_GT)) begin
            push_o.entry.tok0 = lel_pkg::TK_IMP;
          end else if ((state_q == ST_LT_MINUS) && (c == lel_pkg::CH_GT)) begin
            push_o.entry.tok0 = lel_pkg::TK_EQV;
          end else if ((state_q == ST_LT_EQ) && (c == lel_pkg::CH_GT)) begin
            push_o.entry.tok0 = lel_pkg::TK_EQP;
          end
        end
        ST_LT: begin
          if (c == lel_pkg::CH_MINUS) begin
            state_d = ST_LT_MINUS;
          end else if (c == lel_pkg::CH_EQ) begin
            state_d = ST_LT_EQ;
          end else begin
            state_d     = ST_IDLE;
            push_o.push = 1'b1;
          end
        end
        ST_IDENT: begin
          if (is_id) begin
            // Saturate the length and drop characters past the limit.
            if (cnt_q < lel_pkg::ID_LIMIT) begin
              cnt_d             = cnt_q + 6'd1;
              push_o.push       = 1'b1;
              push_o.entry.tok0 = lel_pkg::TK_IDCHAR;
            end
          end else begin
            // Close the identifier, then rescan the character from idle.
            push_o.push       = 1'b1;
            push_o.entry.tok0 = lel_pkg::TK_ID;
            push_o.entry.two  = idle_r.emit;
            push_o.entry.tok1 = idle_r.tok;
            state_d           = idle_r.nxt;
            if (idle_r.nxt == ST_IDENT) begin
              cnt_d = 6'd0;
            end
          end
        end
        default: begin
          push_o.push       = idle_r.emit;
          push_o.entry.tok0 = idle_r.tok;
          state_d           = idle_r.nxt;
          if (idle_r.nxt == ST_IDENT) begin
            cnt_d = 6'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/lel_fifo.sv
// ----------------------------------------------------------------------------
// lel_fifo: token queue
// Small first-in first-out queue of token entries between front and back.
// ----------------------------------------------------------------------------
module lel_fifo #(
  parameter int DEPTH = lel_pkg::FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lel_pkg::lel_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output lel_pkg::lel_head_t head_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lel_pkg::lel_entry_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.entry = mem_q[rd_q];
  assign do_push      = push_i.push & ~full_o;
  assign do_pop       = pop_i & ~head_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/lel_back.sv
// ----------------------------------------------------------------------------
// lel_back: token issue stage
// Splits queue entries into single tokens and holds them in the output register.
// ----------------------------------------------------------------------------
module lel_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lel_pkg::lel_head_t head_i,
  output logic               pop_o,
  lel_token_if.source        out_o
);

  logic       valid_q, valid_d;
  logic       pos_q, pos_d;
  logic [3:0] tok_q, tok_d;
  logic       load;

  assign load = ~valid_q | out_o.ready;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    tok_d   = tok_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = ~head_i.empty;
      if (!head_i.empty) begin
        tok_d = pos_q ? head_i.entry.tok1 : head_i.entry.tok0;
        // Advance to the second token, or retire the entry.
        if (head_i.entry.two && !pos_q) begin
          pos_d = 1'b1;
        end else begin
          pos_d = 1'b0;
          pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.token_kind = tok_q;

endmodule

>>> src/logic_expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// logic_expression_lexer_unit: logic expression lexer
// Tokenizes a character stream of logical expressions into token codes.
// ----------------------------------------------------------------------------
// Path: a character request writes its entry into the token queue, and the token
//   is then loaded into the output register once that register is free.
// Throughput: one character per cycle while the queue has room; a character with
//   two tokens holds the output register for both; the token queue absorbs that.
// Input ready drops only when all FIFO_DEPTH queue entries are in use.
// Reset (async, active low): scanner back to idle, length zero, queue empty,
//   no token valid.
module logic_expression_lexer_unit #(
  parameter int FIFO_DEPTH = lel_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lel_byte_if.sink   in_i,
  lel_token_if.source out_o
);

  lel_pkg::lel_push_t push;
  lel_pkg::lel_head_t head;
  logic               full;
  logic               pop;

  // Front: accept characters, track scan state, build queue entries.
  lel_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  // Queue: decouple scanning from token issue.
  lel_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // Back: issue one token per cycle from the queue head while the output is not stalled.
  lel_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> src/lel_checker.sv
// ----------------------------------------------------------------------------
// lel_checker: port-level checks for the lexer
// Watches the top-level channels and flags timing and coding slips.
// ----------------------------------------------------------------------------
module lel_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] token_kind_i
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // A token on an idle output passes the token queue and then the output register,
  // so its rise must follow the character request that pushed it.
  a_rise_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("token appeared without a character request two cycles earlier");

  // A full queue implies the output register is occupied.
  a_full_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled while no token is offered");

  // Stalled token holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i))
    else $error("stalled token changed or dropped");

  // Only defined token codes leave the block.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> token_kind_i <= 4'd11)
    else $error("undefined token code");

endmodule

bind logic_expression_lexer_unit lel_checker u_lel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .token_kind_i (out_o.token_kind)
);
